[rtl/bole_pkg.sv]
// Shared types and constants for the bounded ordered list engine.
// No dependencies; imported by every module of the block.
package bole_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	// Index field of the cell command, wide enough for the largest supported list.
	localparam int IDX_MAX_W = 8;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_BACK  = 3'd3,
		OP_DEL_FRONT = 3'd4,
		OP_SEARCH    = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic                 insert;
		logic                 shift_down;
		logic                 compare;
		logic [IDX_MAX_W-1:0] idx;
	} cell_cmd_t;

endpackage

[rtl/bounded_ordered_list_engine_top.sv]
// Bounded ordered list engine: a row of cells that shifts on insert and delete.
// Inserts and deletes load their result into the output register on acceptance; a search
// registers the cell compares, then encodes the first match, and takes no new item meanwhile.
// A new item is taken while the previous result waits only if that result leaves in the same cycle.
// Reset (arst_n low) empties the list and clears out_valid; entry contents are not reset.
// Depends on bole_pkg, bole_cell and bole_first_match.
module bounded_ordered_list_engine_top import bole_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     op,
	input  logic [VALUE_W-1:0]  value,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [POS_W-1:0]    found_position,
	output logic [POS_W-1:0]    length
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int EXT_W = CNT_W + POS_W;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  in_accept;
	logic                  load_out;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  found_q;
	logic [POS_W-1:0]      fpos_q;
	logic [POS_W-1:0]      length_q;
	cell_cmd_t             cmd;
	status_t               res_status;
	logic                  ins_req;
	logic [CMP_W-1:0]      ins_pos;
	logic [CMP_W-1:0]      count_ext;
	logic [DATA_WIDTH-1:0] value_dw;
	logic [CAPACITY-1:0]   match_row;
	logic                  enc_found;
	logic [CNT_W-1:0]      enc_pos;
	logic [EXT_W-1:0]      count_d_ext;
	logic [EXT_W-1:0]      count_q_ext;
	logic [EXT_W-1:0]      enc_pos_ext;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	// Values are kept in their low DATA_WIDTH bits, sign-extended when the row is wider.
	generate
		if (DATA_WIDTH >= VALUE_W) begin : g_val_ext
			assign value_dw = DATA_WIDTH'($signed(value));
		end else begin : g_val_trunc
			assign value_dw = value[DATA_WIDTH-1:0];
		end
	endgenerate

	assign in_accept = in_valid && in_ready;
	assign count_ext = CMP_W'(count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept && (op == OP_SEARCH)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State outputs: the output register must be empty or emptying to take an item.
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				load_out = in_accept && (op != OP_SEARCH);
			end
			S_SCAN: begin
				load_out = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// Operation decode.
	always_comb begin
		cmd        = '0;
		res_status = STAT_DONE;
		count_d    = count_q;
		ins_req    = 1'b0;
		ins_pos    = '0;
		case (op)
			OP_INS_FRONT: begin
				ins_req = 1'b1;
				ins_pos = CMP_W'(1);
			end
			OP_INS_BACK: begin
				ins_req = 1'b1;
				ins_pos = count_ext + CMP_W'(1);
			end
			OP_INS_POS: begin
				ins_req = 1'b1;
				ins_pos = CMP_W'(position);
			end
			OP_DEL_BACK: begin
				if (count_q == '0) begin
					res_status = STAT_IGNORED;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_DEL_FRONT: begin
				if (count_q == '0) begin
					res_status = STAT_IGNORED;
				end else begin
					cmd.shift_down = in_accept;
					count_d        = count_q - CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				cmd.compare = in_accept;
			end
			default: begin
				res_status = STAT_IGNORED;
			end
		endcase
		if (ins_req) begin
			if (count_q >= CNT_W'(CAPACITY)) begin
				res_status = STAT_FULL;
			end else if ((ins_pos == '0) || (ins_pos > count_ext + CMP_W'(1))) begin
				res_status = STAT_IGNORED;
			end else begin
				cmd.insert = in_accept;
				cmd.idx    = IDX_MAX_W'(ins_pos - CMP_W'(1));
				count_d    = count_q + CNT_W'(1);
			end
		end
	end

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_d;
			logic [DATA_WIDTH-1:0] right_d;
			if (i == 0) begin : g_first
				assign left_d = value_dw;
			end else begin : g_mid_l
				assign left_d = cell_data[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_d = cell_data[i];
			end else begin : g_mid_r
				assign right_d = cell_data[i+1];
			end
			bole_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.CNT_W      (CNT_W),
				.INDEX      (i)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.value      (value_dw),
				.left_data  (left_d),
				.right_data (right_d),
				.count      (count_q),
				.data       (cell_data[i]),
				.match      (match_row[i])
			);
		end
	endgenerate

	bole_first_match #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_first_match (
		.match    (match_row),
		.found    (enc_found),
		.position (enc_pos)
	);

	assign count_d_ext = EXT_W'(count_d);
	assign count_q_ext = EXT_W'(count_q);
	assign enc_pos_ext = EXT_W'(enc_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				count_q <= count_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == S_SCAN) begin
				status_q <= STAT_DONE;
				found_q  <= enc_found;
				fpos_q   <= enc_pos_ext[POS_W-1:0];
				length_q <= count_q_ext[POS_W-1:0];
			end else begin
				status_q <= res_status;
				found_q  <= 1'b0;
				fpos_q   <= '0;
				length_q <= count_d_ext[POS_W-1:0];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found          = found_q;
	assign found_position = fpos_q;
	assign length         = length_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count exceeds capacity");

	a_search_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (op == OP_SEARCH)) |=> (state_q == S_SCAN) && !in_ready)
		else $error("search did not enter the scan cycle");

	a_length_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (length == count_q_ext[POS_W-1:0]))
		else $error("reported length differs from held count");

	a_notfound_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (found_position == '0))
		else $error("position reported without a match");

endmodule

[rtl/bole_cell.sv]
// One cell of the list row: holds one entry and its search match flag.
// Depends on bole_pkg for the command struct.
module bole_cell import bole_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int CNT_W      = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [CNT_W-1:0]      count,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  match_q;
	logic                  at_idx;
	logic                  above_idx;

	assign at_idx    = (cmd.idx == IDX_MAX_W'(INDEX));
	assign above_idx = (IDX_MAX_W'(INDEX) > cmd.idx);

	// An insert loads the new value at its slot and moves every later entry up by one.
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (at_idx) begin
				data_q <= value;
			end else if (above_idx) begin
				data_q <= left_data;
			end
		end else if (cmd.shift_down) begin
			data_q <= right_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			match_q <= (data_q == value) && (CNT_W'(INDEX) < count);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

[rtl/bole_first_match.sv]
// Finds the first set bit of the registered match row and its 1-based position.
// Depends on bole_pkg for the DEF_CAPACITY default.
module bole_first_match import bole_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int CNT_W    = 5
) (
	input  logic [CAPACITY-1:0] match,
	output logic                found,
	output logic [CNT_W-1:0]    position
);

	logic [CAPACITY-1:0] first_oh;

	// Isolate the lowest set bit; each position then contributes independently.
	assign first_oh = match & (~match + CAPACITY'(1));
	assign found    = |match;

	always_comb begin
		position = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			position = position | ({CNT_W{first_oh[i]}} & CNT_W'(i + 1));
		end
	end

endmodule
